>>> design/scb_pkg.sv
package scb_pkg;

    localparam int SUM_W       = 48;
    localparam int CX_W        = 52;
    localparam int CZ_W        = 34;
    localparam int STAGES      = 24;
    localparam int IDX_W       = 10;
    localparam int NUM_W       = 82;
    localparam int MAG_W       = 50;

    localparam logic signed [CX_W-1:0] INV_GAIN   = 52'sd652032874;
    localparam logic signed [CZ_W-1:0] HALF_TURN  = 34'sd2147483648;
    localparam logic signed [CZ_W-1:0] QUARTER    = 34'sd1073741824;

    localparam logic MODE_ROT = 1'b0;
    localparam logic MODE_VEC = 1'b1;

    localparam logic [1:0] CFG_PHASE_STEP   = 2'd0;
    localparam logic [1:0] CFG_GAIN_VOLTAGE = 2'd1;
    localparam logic [1:0] CFG_GAIN_CURRENT = 2'd2;

    typedef struct packed {
        logic signed [SUM_W-1:0] v_cos;
        logic signed [SUM_W-1:0] v_sin;
        logic signed [SUM_W-1:0] i_cos;
        logic signed [SUM_W-1:0] i_sin;
    } t_sums;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] a;
        begin
            case (i)
                5'd0:  a = 32'd536870912;
                5'd1:  a = 32'd316933406;
                5'd2:  a = 32'd167458907;
                5'd3:  a = 32'd85004756;
                5'd4:  a = 32'd42667331;
                5'd5:  a = 32'd21354465;
                5'd6:  a = 32'd10679838;
                5'd7:  a = 32'd5340245;
                5'd8:  a = 32'd2670163;
                5'd9:  a = 32'd1335087;
                5'd10: a = 32'd667544;
                5'd11: a = 32'd333772;
                5'd12: a = 32'd166886;
                5'd13: a = 32'd83443;
                5'd14: a = 32'd41721;
                5'd15: a = 32'd20860;
                5'd16: a = 32'd10430;
                5'd17: a = 32'd5215;
                5'd18: a = 32'd2607;
                5'd19: a = 32'd1303;
                5'd20: a = 32'd651;
                5'd21: a = 32'd325;
                5'd22: a = 32'd162;
                5'd23: a = 32'd81;
                5'd24: a = 32'd40;
                5'd25: a = 32'd20;
                5'd26: a = 32'd10;
                5'd27: a = 32'd5;
                5'd28: a = 32'd2;
                5'd29: a = 32'd1;
                5'd30: a = 32'd1;
                default: a = 32'd0;
            endcase
            return a;
        end
    endfunction

endpackage

>>> design/scb_cordic.sv
module scb_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_mode,
    input  logic [31:0]                         i_angle,
    input  logic signed [scb_pkg::CX_W-1:0]     i_x,
    input  logic signed [scb_pkg::CX_W-1:0]     i_y,
    output logic                                o_done,
    output logic signed [scb_pkg::CX_W-1:0]     o_x,
    output logic signed [scb_pkg::CX_W-1:0]     o_y,
    output logic signed [scb_pkg::CZ_W-1:0]     o_z
);

    logic                              r_busy;
    logic                              r_done;
    logic [4:0]                        r_cnt;
    logic                              r_mode;
    logic                              r_flip;
    logic                              r_zero;
    logic signed [scb_pkg::CX_W-1:0]   r_x;
    logic signed [scb_pkg::CX_W-1:0]   r_y;
    logic signed [scb_pkg::CZ_W-1:0]   r_z;

    logic signed [scb_pkg::CX_W-1:0]   dx;
    logic signed [scb_pkg::CX_W-1:0]   dy;
    logic signed [scb_pkg::CZ_W-1:0]   da;
    logic                              sigma;
    logic signed [scb_pkg::CZ_W-1:0]   z_in;

    assign dx    = r_y >>> r_cnt;
    assign dy    = r_x >>> r_cnt;
    assign da    = $signed({2'b00, scb_pkg::atan_turn(r_cnt)});
    assign sigma = (r_mode == scb_pkg::MODE_ROT) ? (r_z >= 0) : (r_y < 0);
    assign z_in  = $signed({{2{i_angle[31]}}, i_angle});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == 5'(scb_pkg::STAGES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mode <= i_mode;
            r_flip <= 1'b0;
            r_zero <= 1'b0;
            if (i_mode == scb_pkg::MODE_ROT) begin
                r_x <= scb_pkg::INV_GAIN;
                r_y <= '0;
                if (z_in > scb_pkg::QUARTER) begin
                    r_z    <= z_in - scb_pkg::HALF_TURN;
                    r_flip <= 1'b1;
                end else if (z_in < -scb_pkg::QUARTER) begin
                    r_z    <= z_in + scb_pkg::HALF_TURN;
                    r_flip <= 1'b1;
                end else begin
                    r_z <= z_in;
                end
            end else begin
                r_zero <= (i_x == 0) && (i_y == 0);
                if (i_x < 0) begin
                    r_x <= -i_x;
                    r_y <= -i_y;
                    r_z <= (i_y >= 0) ? scb_pkg::HALF_TURN : -scb_pkg::HALF_TURN;
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end
            end
        end else if (r_busy) begin
            if (sigma) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - da;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + da;
            end
        end
    end

    always_comb begin
        o_done = r_done;
        o_x    = r_x;
        o_y    = r_y;
        o_z    = r_z;
        if (r_mode == scb_pkg::MODE_ROT) begin
            if (r_flip) begin
                o_x = -r_x;
                o_y = -r_y;
            end
        end else begin
            if (r_zero) begin
                o_x = '0;
                o_z = '0;
            end else if (r_z > scb_pkg::HALF_TURN) begin
                o_z = scb_pkg::HALF_TURN;
            end else if (r_z < -scb_pkg::HALF_TURN) begin
                o_z = -scb_pkg::HALF_TURN;
            end
        end
    end

endmodule

>>> design/scb_queue.sv
module scb_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  scb_pkg::t_sums       i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output scb_pkg::t_sums       o_data
);

    scb_pkg::t_sums r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            if (i_push && !i_pop) r_count <= r_count + 2'd1;
            else if (!i_push && i_pop) r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

>>> design/scb_front.sv
module scb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic signed [15:0]   i_voltage_sample,
    input  logic signed [15:0]   i_current_sample,
    input  logic                 i_last_sample,
    input  logic [31:0]          i_phase_step,
    output logic                 o_q_push,
    output scb_pkg::t_sums       o_q_data,
    input  logic                 i_q_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_ROT  = 2'd1;
    localparam logic [1:0] F_MAC  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic signed [15:0]     r_v;
    logic signed [15:0]     r_i;
    logic                   r_last;
    logic signed [15:0]     r_c;
    logic signed [15:0]     r_s;
    logic [31:0]            r_phase;
    scb_pkg::t_sums         r_sums;

    logic                   accept;
    logic [31:0]            angle;
    logic                   c_done;
    logic signed [scb_pkg::CX_W-1:0] c_x;
    logic signed [scb_pkg::CX_W-1:0] c_y;
    logic signed [scb_pkg::CZ_W-1:0] c_z;
    logic signed [31:0]     p_vc;
    logic signed [31:0]     p_vs;
    logic signed [31:0]     p_ic;
    logic signed [31:0]     p_is;

    function automatic logic signed [15:0] wave(input logic signed [scb_pkg::CX_W-1:0] v);
        logic signed [scb_pkg::CX_W-1:0] t;
        begin
            t = (v + 52'sd16384) >>> 15;
            if (t > 52'sd32767) return 16'sh7fff;
            else if (t < -52'sd32768) return 16'sh8000;
            else return t[15:0];
        end
    endfunction

    assign accept   = i_push && (r_state == F_IDLE);
    assign o_full   = (r_state != F_IDLE);
    assign angle    = {r_phase[31 -: scb_pkg::IDX_W], {(32 - scb_pkg::IDX_W){1'b0}}};
    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    assign o_q_data = r_sums;

    assign p_vc = r_v * r_c;
    assign p_vs = r_v * r_s;
    assign p_ic = r_i * r_c;
    assign p_is = r_i * r_s;

    scb_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_mode  (scb_pkg::MODE_ROT),
        .i_angle (angle),
        .i_x     ('0),
        .i_y     ('0),
        .o_done  (c_done),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_z     (c_z)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept) n_state = F_ROT;
            F_ROT:  if (c_done) n_state = F_MAC;
            F_MAC:  n_state = r_last ? F_PUSH : F_IDLE;
            F_PUSH: if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_phase <= '0;
            r_sums  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_MAC) begin
                r_sums.v_cos <= r_sums.v_cos + {{16{p_vc[31]}}, p_vc};
                r_sums.v_sin <= r_sums.v_sin + {{16{p_vs[31]}}, p_vs};
                r_sums.i_cos <= r_sums.i_cos + {{16{p_ic[31]}}, p_ic};
                r_sums.i_sin <= r_sums.i_sin + {{16{p_is[31]}}, p_is};
                r_phase      <= r_phase + i_phase_step;
            end else if (o_q_push) begin
                r_sums  <= '0;
                r_phase <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_v    <= i_voltage_sample;
            r_i    <= i_current_sample;
            r_last <= i_last_sample;
        end
        if (r_state == F_ROT && c_done) begin
            r_c <= wave(c_x);
            r_s <= wave(c_y);
        end
    end

    logic unused_z;
    assign unused_z = ^c_z;

endmodule

>>> design/scb_back.sv
module scb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  scb_pkg::t_sums       i_q_data,
    output logic                 o_q_pop,
    input  logic [31:0]          i_gain_voltage,
    input  logic [31:0]          i_gain_current,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [31:0]          o_magnitude,
    output logic signed [17:0]   o_phase_degrees,
    output logic signed [31:0]   o_real_part,
    output logic signed [31:0]   o_imag_part,
    output logic                 o_no_current
);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_VV   = 4'd1;
    localparam logic [3:0] B_VI   = 4'd2;
    localparam logic [3:0] B_M0   = 4'd3;
    localparam logic [3:0] B_M1   = 4'd4;
    localparam logic [3:0] B_M2   = 4'd5;
    localparam logic [3:0] B_M3   = 4'd6;
    localparam logic [3:0] B_CHK  = 4'd7;
    localparam logic [3:0] B_DIV  = 4'd8;
    localparam logic [3:0] B_RS   = 4'd9;
    localparam logic [3:0] B_RW   = 4'd10;
    localparam logic [3:0] B_MR   = 4'd11;
    localparam logic [3:0] B_MI   = 4'd12;
    localparam logic [3:0] B_FIN  = 4'd13;
    localparam logic [3:0] B_HOLD = 4'd14;

    localparam int NW = scb_pkg::NUM_W;
    localparam int MW = scb_pkg::MAG_W;

    logic [3:0]                      r_state;
    logic [3:0]                      n_state;
    scb_pkg::t_sums                  r_sums;
    logic [MW-1:0]                   r_mv;
    logic [MW-1:0]                   r_mi;
    logic signed [scb_pkg::CZ_W-1:0] r_pv;
    logic signed [scb_pkg::CZ_W-1:0] r_d;
    logic signed [51:0]              r_degp;
    logic [NW-1:0]                   r_num;
    logic [NW-1:0]                   r_den;
    logic [NW-1:0]                   r_rem;
    logic [31:0]                     r_q;
    logic [4:0]                      r_cnt;
    logic signed [33:0]              r_c30;
    logic signed [33:0]              r_s30;
    logic signed [66:0]              r_pr;
    logic signed [66:0]              r_pim;
    logic [31:0]                     r_mag;
    logic signed [17:0]              r_deg;
    logic signed [31:0]              r_real;
    logic signed [31:0]              r_imag;
    logic                            r_nocur;

    logic                            c_start;
    logic                            c_mode;
    logic signed [scb_pkg::CX_W-1:0] c_xi;
    logic signed [scb_pkg::CX_W-1:0] c_yi;
    logic                            c_done;
    logic signed [scb_pkg::CX_W-1:0] c_x;
    logic signed [scb_pkg::CX_W-1:0] c_y;
    logic signed [scb_pkg::CZ_W-1:0] c_z;

    logic [NW:0]                     rem2;
    logic [NW:0]                     den_ext;
    logic                            div_ge;
    logic [31:0]                     q_next;
    logic                            num_bit;
    logic [NW+15:0]                  lim;
    logic signed [51:0]              deg_t;

    function automatic logic signed [31:0] sat_round(input logic signed [66:0] p);
        logic signed [66:0] t;
        begin
            t = (p + 67'sd536870912) >>> 30;
            if (t > 67'sd2147483647) return 32'sh7fffffff;
            else if (t < -67'sd2147483648) return 32'sh80000000;
            else return t[31:0];
        end
    endfunction

    assign o_q_pop = (r_state == B_IDLE) && i_q_valid;
    assign o_empty = (r_state != B_HOLD);

    assign o_magnitude     = r_mag;
    assign o_phase_degrees = r_deg;
    assign o_real_part     = r_real;
    assign o_imag_part     = r_imag;
    assign o_no_current    = r_nocur;

    always_comb begin
        c_start = 1'b0;
        c_mode  = scb_pkg::MODE_VEC;
        c_xi    = {{4{i_q_data.v_cos[47]}}, i_q_data.v_cos};
        c_yi    = {{4{i_q_data.v_sin[47]}}, i_q_data.v_sin};
        unique case (r_state)
            B_IDLE: c_start = i_q_valid;
            B_VV: begin
                c_start = c_done;
                c_xi    = {{4{r_sums.i_cos[47]}}, r_sums.i_cos};
                c_yi    = {{4{r_sums.i_sin[47]}}, r_sums.i_sin};
            end
            B_RS: begin
                c_start = 1'b1;
                c_mode  = scb_pkg::MODE_ROT;
            end
            default: c_start = 1'b0;
        endcase
    end

    scb_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_mode  (c_mode),
        .i_angle (r_d[31:0]),
        .i_x     (c_xi),
        .i_y     (c_yi),
        .o_done  (c_done),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_z     (c_z)
    );

    // restoring divide: the quotient is known to fit 32 bits
    assign num_bit = r_cnt[4] ? 1'b0 : r_num[~r_cnt[3:0]];
    assign rem2    = {r_rem, num_bit};
    assign den_ext = {1'b0, r_den};
    assign div_ge  = (rem2 >= den_ext);
    assign q_next  = {r_q[30:0], div_ge};
    assign lim     = {r_den, 16'd0};
    assign deg_t   = r_degp + 52'sd2147483648;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (i_q_valid) n_state = B_VV;
            B_VV:   if (c_done) n_state = B_VI;
            B_VI:   if (c_done) n_state = B_M0;
            B_M0:   n_state = B_M1;
            B_M1:   n_state = B_M2;
            B_M2:   n_state = B_M3;
            B_M3:   n_state = B_CHK;
            B_CHK: begin
                if (r_nocur || ({16'd0, r_num} >= lim)) n_state = B_RS;
                else n_state = B_DIV;
            end
            B_DIV:  if (r_cnt == 5'd31) n_state = B_RS;
            B_RS:   n_state = B_RW;
            B_RW:   if (c_done) n_state = B_MR;
            B_MR:   n_state = B_MI;
            B_MI:   n_state = B_FIN;
            B_FIN:  n_state = B_HOLD;
            B_HOLD: if (i_pop) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: if (i_q_valid) r_sums <= i_q_data;
            B_VV: begin
                if (c_done) begin
                    r_mv <= c_x[MW-1:0];
                    r_pv <= c_z;
                end
            end
            B_VI: begin
                if (c_done) begin
                    r_mi    <= c_x[MW-1:0];
                    r_d     <= r_pv - c_z;
                    r_nocur <= (r_sums.i_cos == 0) && (r_sums.i_sin == 0);
                end
            end
            B_M0: begin
                r_num  <= NW'(r_mv[31:0] * i_gain_current);
                r_degp <= 52'(r_d * 52'sd92160);
            end
            B_M1: begin
                r_num <= r_num + (NW'(r_mv[MW-1:32] * i_gain_current) << 32);
                r_deg <= deg_t[49:32];
            end
            B_M2: r_den <= NW'(r_mi[31:0] * i_gain_voltage);
            B_M3: r_den <= r_den + (NW'(r_mi[MW-1:32] * i_gain_voltage) << 32);
            B_CHK: begin
                r_mag <= 32'hffffffff;
                r_rem <= r_num >> 16;
                r_q   <= '0;
                r_cnt <= '0;
            end
            B_DIV: begin
                r_rem <= div_ge ? NW'(rem2 - den_ext) : rem2[NW-1:0];
                r_q   <= q_next;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) r_mag <= q_next;
            end
            B_RW: begin
                if (c_done) begin
                    r_c30 <= c_x[33:0];
                    r_s30 <= c_y[33:0];
                end
            end
            B_MR:  r_pr  <= $signed({1'b0, r_mag}) * r_c30;
            B_MI:  r_pim <= $signed({1'b0, r_mag}) * r_s30;
            B_FIN: begin
                r_real <= sat_round(r_pr);
                r_imag <= sat_round(r_pim);
            end
            default: ;
        endcase
    end

endmodule

>>> design/single_bin_impedance_correlator_core.sv
// single-bin impedance correlator
// input channel: voltage and current sample pairs, a transfer when push is
// high and full is low; last_sample closes a record and requests a result
// config channel: i_cfg_valid/o_cfg_ready with register index and data
// (0 phase step, 1 voltage gain, 2 current gain); other indexes are dropped
// the front takes a new sample only once it is done with the last: the rotation
// cordic that makes the reference cosine and sine runs one stage per cycle
// on the last sample the four sums move into a two-entry queue and the back
// computes the result: two vectoring cordic passes, split multiplies, a
// 32-step divide when the quotient fits, and one rotation pass
// a result sits on the output ports while empty is low until popped; the
// back waits there, and the front keeps filling the next record meanwhile
// synchronous active-low reset clears the sums, the phase and the queue and
// sets both gains to one
module single_bin_impedance_correlator_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [15:0]   i_voltage_sample,
    input  logic signed [15:0]   i_current_sample,
    input  logic                 i_last_sample,
    output logic                 empty,
    input  logic                 pop,
    output logic [31:0]          o_magnitude,
    output logic signed [17:0]   o_phase_degrees,
    output logic signed [31:0]   o_real_part,
    output logic signed [31:0]   o_imag_part,
    output logic                 o_no_current,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    logic [31:0]    r_phase_step;
    logic [31:0]    r_gain_voltage;
    logic [31:0]    r_gain_current;

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    scb_pkg::t_sums q_wdata;
    scb_pkg::t_sums q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= '0;
            r_gain_voltage <= 32'd65536;
            r_gain_current <= 32'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                scb_pkg::CFG_PHASE_STEP:   r_phase_step   <= i_cfg_data;
                scb_pkg::CFG_GAIN_VOLTAGE: r_gain_voltage <= i_cfg_data;
                scb_pkg::CFG_GAIN_CURRENT: r_gain_current <= i_cfg_data;
                default: ;
            endcase
        end
    end

    scb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_voltage_sample (i_voltage_sample),
        .i_current_sample (i_current_sample),
        .i_last_sample    (i_last_sample),
        .i_phase_step     (r_phase_step),
        .o_q_push         (q_push),
        .o_q_data         (q_wdata),
        .i_q_full         (q_full)
    );

    scb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    scb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (q_rdata),
        .o_q_pop         (q_pop),
        .i_gain_voltage  (r_gain_voltage),
        .i_gain_current  (r_gain_current),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_magnitude     (o_magnitude),
        .o_phase_degrees (o_phase_degrees),
        .o_real_part     (o_real_part),
        .o_imag_part     (o_imag_part),
        .o_no_current    (o_no_current)
    );

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("record queue written while full");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("record queue read while empty");

    a_front_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("front free right after a sample transfer");

    a_result_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty) |=> empty)
        else $error("result still shown after its transfer");

endmodule
